// File: sv/kpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_pkg
// shared types and constants for the k-permutation unranking block
// ----------------------------------------------------------------------------
package kpu_pkg;
	localparam int MaxN = 12;
	localparam int CntW = 4;
	localparam int RankW = 32;
	localparam int ProdW = 34;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TOTAL,
		ST_DENOM,
		ST_MUL,
		ST_DIV,
		ST_PICK,
		ST_EMIT
	} kpu_state_t;

	function automatic logic [CntW-1:0] sat_reg(input logic [CntW-1:0] v);
		return (v > CntW'(MaxN)) ? CntW'(MaxN) : v;
	endfunction
endpackage
`default_nettype wire

// File: sv/k_permutation_unrank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_permutation_unrank
// lexicographic unranking of k-permutations, one result per position
// ----------------------------------------------------------------------------
// order: after the accepting edge the full product is built and checked, then for
// each position p come the 4-bit product steps, the divider, pick and emit
// busy while a rank is in progress; a new rank can be taken with start from
// the first cycle with busy low
// out of range: one result per cycle once the full product is checked
// reset: asynchronous active low; pool_size 12, draw_length 1, idle; no stalls
module k_permutation_unrank
	import kpu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [RankW-1:0] rank,
	output logic                  strobe,
	output logic      [CntW-1:0]  element,
	output logic      [CntW-1:0]  position,
	output logic                  last,
	output logic                  out_of_range
);
	localparam logic [2:0] AddrPool = 3'd0;
	localparam logic [2:0] AddrDraw = 3'd4;

	logic [CntW-1:0]  pool_q, draw_q, n_q, k_q, pos_q, elem_q;
	logic [CntW-1:0]  fac_q, tcnt_q, pick_idx;
	logic [RankW-1:0] rest_q;
	logic [ProdW-1:0] den_q;
	logic             bad_q, bad_d;
	kpu_state_t       state_q, state_d;
	logic             div_go, div_done, wr;
	logic [RankW-1:0] div_quot, div_rem;
	logic [CntW:0]    chain [MaxN+1];
	logic [MaxN-1:0]  hits;
	logic             clear_cells, take;

	// register port
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= CntW'(12);
			draw_q <= CntW'(1);
		end else if (wr) begin
			case (paddr)
				AddrPool: pool_q <= pwdata[CntW-1:0];
				AddrDraw: draw_q <= pwdata[CntW-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr)
			AddrPool: prdata = {28'd0, pool_q};
			AddrDraw: prdata = {28'd0, draw_q};
			default:  prdata = '0;
		endcase
	end

	// chain of element cells
	assign chain[0] = '0;
	for (genvar g = 0; g < MaxN; g++) begin : g_cell
		kpu_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(clear_cells), .take(take),
			.active(CntW'(g) < n_q), .quot(div_quot[CntW-1:0]),
			.cnt_in(chain[g]), .cnt_out(chain[g+1]), .hit(hits[g])
		);
	end

	// index of the picked cell
	always_comb begin
		pick_idx = '0;
		for (int e = 0; e < MaxN; e++)
			if (hits[e]) pick_idx = CntW'(e);
	end

	kpu_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(rest_q),
		.divisor(den_q), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	// draw length against pool size, and rank against the full count, once the product is complete
	assign bad_d = (k_q > n_q) || ({2'b00, rest_q} >= den_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start && draw_q != '0) state_d = ST_CHECK;
			ST_CHECK: state_d = ST_TOTAL;
			ST_TOTAL: if (tcnt_q == '0) state_d = bad_d ? ST_EMIT : ST_DENOM;
			ST_DENOM: state_d = ST_MUL;
			ST_MUL:   if (tcnt_q == '0) state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_PICK;
			ST_PICK:  state_d = ST_EMIT;
			ST_EMIT:  state_d = (pos_q + 1'b1 == k_q) ? ST_IDLE :
					(bad_q ? ST_EMIT : ST_DENOM);
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy = state_q != ST_IDLE;
		div_go = (state_q == ST_MUL) && (tcnt_q == '0);
		take = state_q == ST_PICK;
		clear_cells = state_q == ST_IDLE;
		strobe = state_q == ST_EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath; falling products built one 4-bit factor per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= sat_reg(pool_q);
				k_q <= sat_reg(draw_q);
				rest_q <= rank;
				pos_q <= '0;
			end
			ST_CHECK: begin
				den_q <= ProdW'(1);
				fac_q <= n_q;
				tcnt_q <= k_q;
			end
			ST_TOTAL: begin
				if (tcnt_q != '0) begin
					den_q <= ProdW'(den_q * fac_q);
					fac_q <= fac_q - 1'b1;
					tcnt_q <= tcnt_q - 1'b1;
				end else begin
					bad_q <= bad_d;
					elem_q <= '0;
				end
			end
			ST_DENOM: begin
				den_q <= ProdW'(1);
				fac_q <= n_q - 1'b1 - pos_q;
				tcnt_q <= k_q - 1'b1 - pos_q;
			end
			ST_MUL: begin
				if (tcnt_q != '0) begin
					den_q <= ProdW'(den_q * fac_q);
					fac_q <= fac_q - 1'b1;
					tcnt_q <= tcnt_q - 1'b1;
				end
			end
			ST_PICK: begin
				rest_q <= div_rem;
				elem_q <= pick_idx;
			end
			ST_EMIT: pos_q <= pos_q + 1'b1;
			default: ;
		endcase
	end

	assign element = bad_q ? '0 : elem_q;
	assign position = pos_q;
	assign last = pos_q + 1'b1 == k_q;
	assign out_of_range = bad_q;

	// a result is never shown while idle
	a_no_idle_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("strobe while idle");
	// the last result returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy) else $error("not idle after last");
	// at most one cell picked
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> $onehot0(hits)) else $error("several cells picked");
endmodule
`default_nettype wire

// File: sv/kpu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_cell
// one element slot of the selection chain: holds its used mark and counts
// free slots from the left, handing the running count to its neighbour
// ----------------------------------------------------------------------------
module kpu_cell
	import kpu_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            clear,
	input  wire logic            take,
	input  wire logic            active,
	input  wire logic [CntW-1:0] quot,
	input  wire logic [CntW:0]   cnt_in,
	output logic      [CntW:0]   cnt_out,
	output logic                 hit
);
	logic used_q;

	// this slot is picked when it is free and exactly quot free slots lie left
	assign hit = active && !used_q && (cnt_in == {1'b0, quot});
	assign cnt_out = (active && !used_q) ? cnt_in + 1'b1 : cnt_in;

	// used mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			used_q <= 1'b0;
		else if (clear)
			used_q <= 1'b0;
		else if (take && hit)
			used_q <= 1'b1;
	end
endmodule
`default_nettype wire

// File: sv/kpu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kpu_div
	import kpu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [RankW-1:0] dividend,
	input  wire logic [ProdW-1:0] divisor,
	output logic                  done,
	output logic      [RankW-1:0] quot,
	output logic      [RankW-1:0] rem
);
	logic [ProdW-1:0] rem_q;
	logic [RankW-1:0] quo_q;
	logic [ProdW-1:0] den_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic [ProdW-1:0] trial;

	assign trial = {rem_q[ProdW-2:0], quo_q[RankW-1]};
	assign quot = quo_q;
	assign rem = rem_q[RankW-1:0];
	assign done = run_q && (cnt_q == 6'd0);

	// shift-subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'(RankW);
		end else if (run_q) begin
			if (cnt_q == 6'd0)
				run_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q && cnt_q != 6'd0) begin
			if (trial >= den_q) begin
				rem_q <= trial - den_q;
				quo_q <= {quo_q[RankW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[RankW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire
